>>> src/bums_pkg.sv
// Shared types, microcode encoding and control ROM for the bottom-up merge sorter.
// No dependencies; used by bums_seq and bottom_up_merge_sort.
package bums_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned PC_W          = 4;

  // datapath actions, one per control word
  typedef enum logic [3:0] {
    ACT_LOAD,
    ACT_SORT_INIT,
    ACT_BASE_CLR,
    ACT_RUN_INIT,
    ACT_READ,
    ACT_MERGE,
    ACT_NEXT_RUN,
    ACT_PASS_END,
    ACT_EMIT_INIT,
    ACT_EMIT_READ,
    ACT_EMIT,
    ACT_DONE
  } act_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_LAST,
    COND_WIDTH_GE_N,
    COND_BASE_GE_N,
    COND_MERGE_MORE,
    COND_EMIT_MORE
  } cond_e;

  typedef struct packed {
    act_e            act;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic last_xfer;
    logic width_ge_n;
    logic base_ge_n;
    logic merge_more;
    logic emit_more;
    logic hold;
  } stat_t;

  localparam logic [PC_W-1:0] ST_LOAD      = 4'd0;
  localparam logic [PC_W-1:0] ST_SORT_INIT = 4'd1;
  localparam logic [PC_W-1:0] ST_PASS_TEST = 4'd2;
  localparam logic [PC_W-1:0] ST_RUN_INIT  = 4'd3;
  localparam logic [PC_W-1:0] ST_READ      = 4'd4;
  localparam logic [PC_W-1:0] ST_MERGE     = 4'd5;
  localparam logic [PC_W-1:0] ST_NEXT_RUN  = 4'd6;
  localparam logic [PC_W-1:0] ST_PASS_END  = 4'd7;
  localparam logic [PC_W-1:0] ST_EMIT_INIT = 4'd8;
  localparam logic [PC_W-1:0] ST_EMIT_READ = 4'd9;
  localparam logic [PC_W-1:0] ST_EMIT      = 4'd10;
  localparam logic [PC_W-1:0] ST_DONE      = 4'd11;

  // control program: jump to target when cond holds, else fall through
  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    w = '{act: ACT_DONE, cond: COND_ALWAYS, target: ST_LOAD};
    unique case (pc)
      ST_LOAD:      w = '{act: ACT_LOAD,      cond: COND_NO_LAST,    target: ST_LOAD};
      ST_SORT_INIT: w = '{act: ACT_SORT_INIT, cond: COND_NONE,       target: ST_LOAD};
      ST_PASS_TEST: w = '{act: ACT_BASE_CLR,  cond: COND_WIDTH_GE_N, target: ST_EMIT_INIT};
      ST_RUN_INIT:  w = '{act: ACT_RUN_INIT,  cond: COND_BASE_GE_N,  target: ST_PASS_END};
      ST_READ:      w = '{act: ACT_READ,      cond: COND_NONE,       target: ST_LOAD};
      ST_MERGE:     w = '{act: ACT_MERGE,     cond: COND_MERGE_MORE, target: ST_READ};
      ST_NEXT_RUN:  w = '{act: ACT_NEXT_RUN,  cond: COND_ALWAYS,     target: ST_RUN_INIT};
      ST_PASS_END:  w = '{act: ACT_PASS_END,  cond: COND_ALWAYS,     target: ST_PASS_TEST};
      ST_EMIT_INIT: w = '{act: ACT_EMIT_INIT, cond: COND_NONE,       target: ST_LOAD};
      ST_EMIT_READ: w = '{act: ACT_EMIT_READ, cond: COND_NONE,       target: ST_LOAD};
      ST_EMIT:      w = '{act: ACT_EMIT,      cond: COND_EMIT_MORE,  target: ST_EMIT_READ};
      ST_DONE:      w = '{act: ACT_DONE,      cond: COND_ALWAYS,     target: ST_LOAD};
      default:      w = '{act: ACT_DONE,      cond: COND_ALWAYS,     target: ST_LOAD};
    endcase
    return w;
  endfunction

endpackage

>>> src/bottom_up_merge_sort.sv
// Bottom-up merge sorter: top level with datapath, ping-pong element memories
// and output register. Depends on bums_pkg and bums_seq.
//
//   channel  handshake                 payload                                 dir
//   in       in_valid_i, in_ready_o    value_i, last_i                         in
//   out      out_valid_o, out_ready_i  sorted_value_o, last_out_o, overflow_o  out
//
// Load accepts one item per cycle. Sorting runs ceil(log2 n) passes, ping-ponging
// between two memories; each element is merged by a memory read, then a compare
// and write, and each run pair and each pass add bookkeeping steps.
// Each emitted element takes a registered memory read, then an output register load.
// Reset clears the step counter, element count, overflow flag and output valid.
// A stalled output holds the sequencer on the emit step; input waits meanwhile.
module bottom_up_merge_sort #(
  parameter int unsigned MAX_ITEMS = bums_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [bums_pkg::VAL_W-1:0] value_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [bums_pkg::VAL_W-1:0] sorted_value_o,
  output logic                              last_out_o,
  output logic                              overflow_o
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned WW = CW + 2;
  localparam int unsigned VW = bums_pkg::VAL_W;

  bums_pkg::act_e  act;
  bums_pkg::stat_t stat;

  logic [CW-1:0] cnt_q, left_q, right_q, mid_q, hi_q, pos_q;
  logic [WW-1:0] width_q, base_q;
  logic          drop_q, src_q, out_valid_q;
  logic [VW-1:0] out_val_q;
  logic          out_last_q, out_ovf_q;

  logic [VW-1:0] mem_a [MAX_ITEMS];
  logic [VW-1:0] mem_b [MAX_ITEMS];
  logic [VW-1:0] ra_l_q, ra_r_q, rb_l_q, rb_r_q;
  logic [VW-1:0] rd_l, rd_r, wr_data;

  logic          in_xfer, store_ok, take_left, out_load, rd_en;
  logic          we_a, we_b;
  logic [AW-1:0] addr_l, addr_r, addr_wa;
  logic [WW-1:0] n_w, mid_sum, hi_sum;
  logic [CW:0]   pos_p1;

  bums_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .act_o  (act)
  );

  assign in_ready_o = (act == bums_pkg::ACT_LOAD);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign store_ok   = cnt_q < CW'(MAX_ITEMS);

  assign n_w     = WW'(cnt_q);
  assign mid_sum = base_q + width_q;
  assign hi_sum  = base_q + (width_q << 1);
  assign pos_p1  = {1'b0, pos_q} + 1'b1;

  assign rd_l = src_q ? rb_l_q : ra_l_q;
  assign rd_r = src_q ? rb_r_q : ra_r_q;

  // take left on ties; exhausted side never wins
  assign take_left = (right_q >= hi_q) ||
                     ((left_q < mid_q) && ($signed(rd_l) <= $signed(rd_r)));
  assign wr_data   = take_left ? rd_l : rd_r;

  assign out_load = (act == bums_pkg::ACT_EMIT) && !(out_valid_q && !out_ready_i);

  always_comb begin
    stat.last_xfer  = in_xfer && last_i;
    stat.width_ge_n = width_q >= n_w;
    stat.base_ge_n  = base_q >= n_w;
    stat.merge_more = pos_p1 < {1'b0, hi_q};
    stat.emit_more  = pos_p1 < {1'b0, cnt_q};
    stat.hold       = (act == bums_pkg::ACT_EMIT) && !out_load;
  end

  // memory ports
  assign rd_en   = (act == bums_pkg::ACT_READ) || (act == bums_pkg::ACT_EMIT_READ);
  assign addr_l  = (act == bums_pkg::ACT_EMIT_READ) ? pos_q[AW-1:0] : left_q[AW-1:0];
  assign addr_r  = right_q[AW-1:0];
  assign we_a    = (in_xfer && store_ok) || ((act == bums_pkg::ACT_MERGE) && src_q);
  assign we_b    = (act == bums_pkg::ACT_MERGE) && !src_q;
  assign addr_wa = in_xfer ? cnt_q[AW-1:0] : pos_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[addr_wa] <= in_xfer ? value_i : wr_data;
    end
    if (rd_en) begin
      ra_l_q <= mem_a[addr_l];
      ra_r_q <= mem_a[addr_r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[pos_q[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rb_l_q <= mem_b[addr_l];
      rb_r_q <= mem_b[addr_r];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (store_ok) begin
          cnt_q <= cnt_q + 1'b1;
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (act == bums_pkg::ACT_DONE) begin
        cnt_q  <= '0;
        drop_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // run bookkeeping and output payload
  always_ff @(posedge clk_i) begin
    case (act)
      bums_pkg::ACT_SORT_INIT: begin
        width_q <= WW'(1);
        src_q   <= 1'b0;
      end
      bums_pkg::ACT_BASE_CLR: base_q <= '0;
      bums_pkg::ACT_RUN_INIT: begin
        left_q  <= base_q[CW-1:0];
        pos_q   <= base_q[CW-1:0];
        mid_q   <= (mid_sum < n_w) ? mid_sum[CW-1:0] : cnt_q;
        right_q <= (mid_sum < n_w) ? mid_sum[CW-1:0] : cnt_q;
        hi_q    <= (hi_sum < n_w) ? hi_sum[CW-1:0] : cnt_q;
      end
      bums_pkg::ACT_MERGE: begin
        if (take_left) begin
          left_q <= left_q + 1'b1;
        end else begin
          right_q <= right_q + 1'b1;
        end
        pos_q <= pos_p1[CW-1:0];
      end
      bums_pkg::ACT_NEXT_RUN: base_q <= hi_sum;
      bums_pkg::ACT_PASS_END: begin
        width_q <= width_q << 1;
        src_q   <= !src_q;
      end
      bums_pkg::ACT_EMIT_INIT: pos_q <= '0;
      bums_pkg::ACT_EMIT: begin
        if (out_load) begin
          out_val_q  <= rd_l;
          out_last_q <= pos_p1 == {1'b0, cnt_q};
          out_ovf_q  <= drop_q;
          pos_q      <= pos_p1[CW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_val_q;
  assign last_out_o     = out_last_q;
  assign overflow_o     = out_ovf_q;

  // element count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ITEMS))
    else $error("element count beyond store depth");

  // merge cursors stay inside their runs
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act == bums_pkg::ACT_MERGE) |->
      (pos_q < hi_q) && (left_q <= mid_q) && (right_q <= hi_q))
    else $error("merge cursor out of run");

  // output position equals elements consumed from both runs
  a_cursor_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act == bums_pkg::ACT_READ || act == bums_pkg::ACT_MERGE) |->
      ({1'b0, pos_q} + {1'b0, mid_q}) == ({1'b0, left_q} + {1'b0, right_q}))
    else $error("merge cursors out of step");

  // input ready drops right after the final element of a set is taken
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.last_xfer) |=> !in_ready_o)
    else $error("input ready right after final element");

endmodule

>>> src/bums_seq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on bums_pkg.
module bums_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bums_pkg::stat_t   stat_i,
  output bums_pkg::act_e    act_o
);

  logic [bums_pkg::PC_W-1:0] pc_d, pc_q;
  bums_pkg::uword_t          word;
  logic                      jump;

  always_comb begin
    word = bums_pkg::ucode(pc_q);
    case (word.cond)
      bums_pkg::COND_NONE:       jump = 1'b0;
      bums_pkg::COND_ALWAYS:     jump = 1'b1;
      bums_pkg::COND_NO_LAST:    jump = !stat_i.last_xfer;
      bums_pkg::COND_WIDTH_GE_N: jump = stat_i.width_ge_n;
      bums_pkg::COND_BASE_GE_N:  jump = stat_i.base_ge_n;
      bums_pkg::COND_MERGE_MORE: jump = stat_i.merge_more;
      bums_pkg::COND_EMIT_MORE:  jump = stat_i.emit_more;
      default:                   jump = 1'b1;
    endcase
    if (stat_i.hold) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  assign act_o = word.act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= bums_pkg::ST_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> verif/tb_bottom_up_merge_sort.sv
// Self-checking testbench for bottom_up_merge_sort: streams sets of signed values,
// predicts the sorted output in-line and checks every output transfer.
// Depends on bums_pkg and the bottom_up_merge_sort RTL.
`timescale 1ns / 100ps

module tb_bottom_up_merge_sort;

  localparam int unsigned DEPTH       = bums_pkg::MAX_ITEMS_DEF;
  localparam int unsigned W           = bums_pkg::VAL_W;
  localparam int unsigned ITEMS_PHASE = 68;
  localparam int unsigned DRAIN_CYC   = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic signed [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};

  typedef struct packed {
    logic signed [W-1:0] value;
    logic                last;
  } elem_t;

  typedef struct packed {
    logic signed [W-1:0] value;
    logic                last;
    logic                ovf;
  } sorted_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic signed [W-1:0] value_i     = '0;
  logic                last_i      = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic signed [W-1:0] sorted_value_o;
  logic                last_out_o;
  logic                overflow_o;

  bottom_up_merge_sort dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_o (sorted_value_o),
    .last_out_o     (last_out_o),
    .overflow_o     (overflow_o)
  );

  elem_t       elements_to_send[$];
  sorted_t     pending_sorted[$];

  // predictor state: the set being collected
  logic signed [W-1:0] held_vals[DEPTH];
  int unsigned         held_cnt     = 0;
  logic                held_dropped = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;
  int unsigned elems_accepted = 0;
  int unsigned sets_sorted    = 0;
  int unsigned ovf_sets       = 0;
  int unsigned cycles         = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // bottom-up merge of the held set; left run wins ties
  function automatic void sort_held();
    logic signed [W-1:0] scratch[DEPTH];
    int unsigned run_w, base, mid, hi, lft, rgt, pos;
    for (run_w = 1; run_w < held_cnt; run_w = run_w * 2) begin
      for (base = 0; base < held_cnt; base = base + 2 * run_w) begin
        mid = base + run_w;
        if (mid < held_cnt) begin
          hi  = (mid + run_w > held_cnt) ? held_cnt : mid + run_w;
          lft = base;
          rgt = mid;
          pos = 0;
          while (lft < mid || rgt < hi) begin
            if (rgt >= hi || (lft < mid && held_vals[lft] <= held_vals[rgt])) begin
              scratch[pos] = held_vals[lft];
              lft++;
            end else begin
              scratch[pos] = held_vals[rgt];
              rgt++;
            end
            pos++;
          end
          for (int unsigned i = 0; i < pos; i++) held_vals[base + i] = scratch[i];
        end
      end
    end
  endfunction

  // one accepted input transfer; a last element flushes the set into the expectations
  function automatic void absorb_element(logic signed [W-1:0] v, logic lst);
    sorted_t r;
    if (held_cnt < DEPTH) begin
      held_vals[held_cnt] = v;
      held_cnt++;
    end else begin
      held_dropped = 1'b1;
    end
    if (lst) begin
      sort_held();
      for (int unsigned k = 0; k < held_cnt; k++) begin
        r.value = held_vals[k];
        r.last  = (k + 1 == held_cnt);
        r.ovf   = held_dropped;
        pending_sorted.insert(pending_sorted.size(), r);
      end
      sets_sorted++;
      if (held_dropped) ovf_sets++;
      held_cnt     = 0;
      held_dropped = 1'b0;
    end
  endfunction

  // input side
  always @(posedge clk_i or negedge rst_ni) begin : drive_in
    elem_t nxt;
    logic  slot_free;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
      last_i     <= 1'b0;
    end else begin
      slot_free = !in_valid_i || in_ready_o;
      if (in_valid_i && in_ready_o) begin
        absorb_element(value_i, last_i);
        elems_accepted++;
      end
      if (slot_free) begin
        if (elements_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = elements_to_send.pop_front();
          in_valid_i <= 1'b1;
          value_i    <= nxt.value;
          last_i     <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i or negedge rst_ni) begin : watch_out
    sorted_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_sorted.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result value %0d last %0b ovf %0b", $time,
                   sorted_value_o, last_out_o, overflow_o);
        end else begin
          exp_r = pending_sorted.pop_front();
          if (sorted_value_o !== exp_r.value || last_out_o !== exp_r.last ||
              overflow_o !== exp_r.ovf) begin
            mismatches++;
            $display("%0t: mismatch expected value %0d last %0b ovf %0b, got %0d %0b %0b",
                     $time, exp_r.value, exp_r.last, exp_r.ovf,
                     sorted_value_o, last_out_o, overflow_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, pending_sorted.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void push_elem(logic signed [W-1:0] v, logic lst);
    elem_t e;
    e.value = v;
    e.last  = lst;
    elements_to_send.insert(elements_to_send.size(), e);
  endfunction

  // mix of full-range, clustered (forces ties) and corner values
  function automatic logic signed [W-1:0] pick_value();
    logic signed [W-1:0] v;
    case ($urandom_range(3))
      0, 1:    v = $urandom;
      2:       v = $signed($urandom_range(16)) - 8;
      default: begin
        case ($urandom_range(5))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2:       v = VAL_MIN + 1;
          3:       v = VAL_MAX - 1;
          4:       v = -1;
          default: v = 0;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_set_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(8, 1);
    if (r < 90) return $urandom_range(24, 9);
    if (r < 95) return DEPTH;
    return $urandom_range(DEPTH + 4, DEPTH + 1);
  endfunction

  function automatic void queue_random_set(int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_elem(pick_value(), i + 1 == n);
  endfunction

  initial begin : stimulus
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    int unsigned queued, n;
    idle_tab  = '{0, 48, 0, 38};
    stall_tab = '{0, 0, 48, 38};

    // directed: single element, extremes, ties, reversed order, pair
    push_elem(VAL_MAX, 1'b1);
    push_elem(VAL_MIN, 1'b0); push_elem(VAL_MAX, 1'b0); push_elem(0, 1'b0);
    push_elem(-1, 1'b0);      push_elem(1, 1'b0);       push_elem(VAL_MIN, 1'b0);
    push_elem(VAL_MAX, 1'b0); push_elem(-2, 1'b1);
    push_elem(5, 1'b0); push_elem(5, 1'b0); push_elem(5, 1'b1);
    push_elem(VAL_MAX, 1'b0); push_elem(100, 1'b0); push_elem(50, 1'b0);
    push_elem(0, 1'b0);       push_elem(-50, 1'b0); push_elem(-100, 1'b0);
    push_elem(VAL_MIN, 1'b1);
    push_elem(0, 1'b0); push_elem(-1, 1'b1);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      queued = 0;
      // one full store, one overflowing set, one with only the last element dropped
      if (ph > 0) begin
        n = (ph == 1) ? DEPTH : (ph == 2) ? DEPTH + 2 : DEPTH + 1;
        queue_random_set(n);
        queued += n;
      end
      while (queued < ITEMS_PHASE) begin
        n = pick_set_size();
        queue_random_set(n);
        queued += n;
      end
      while (elements_to_send.size() != 0 || in_valid_i) @(negedge clk_i);
    end

    while (pending_sorted.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);

    $display("Sorted %0d sets from %0d input transfers, %0d with dropped elements;",
             sets_sorted, elems_accepted, ovf_sets);
    $display("checked %0d output transfers across four handshake pressure phases.",
             results_seen);
    if (mismatches == 0 && pending_sorted.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
src/bums_pkg.sv
src/bums_seq.sv
src/bottom_up_merge_sort.sv
verif/tb_bottom_up_merge_sort.sv
